### design/assert_macros.svh
// Assertion macros for the RTL files (included by the top level).
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define PFNB_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define PFNB_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define PFNB_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define PFNB_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

### design/pfnb_pkg.sv
// ----------------------------------------------------------------------------
// pfnb_pkg
// Types, widths, codes and helpers for the phase folding block.
// ----------------------------------------------------------------------------
package pfnb_pkg;

  localparam int DEF_MAX_CHANNELS = 64;
  localparam int DEF_MAX_BINS     = 256;

  localparam int VAL_W   = 32;
  localparam int PHASE_W = 32;
  localparam int SUM_W   = 56;
  localparam int HIT_W   = 24;
  localparam int SCNT_W  = 24;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int OCH_W   = 6;
  localparam int OBIN_W  = 8;
  localparam int STAT_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES      = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_VALUE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SREAD,
    S_ACC,
    S_RD,
    S_RDIV,
    S_MADDR,
    S_MDATA,
    S_MDIV,
    S_MFDIV
  } state_t;

  // Clamp a 56-bit quotient to the signed 32-bit range.
  function automatic logic [VAL_W-1:0] sat32(input logic [SUM_W-1:0] q);
    logic fits;
    fits = (q[SUM_W-1:VAL_W-1] == '0) || (q[SUM_W-1:VAL_W-1] == '1);
    if (fits) begin
      sat32 = q[VAL_W-1:0];
    end else if (q[SUM_W-1]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7FFF_FFFF;
    end
  endfunction

endpackage

### design/pfnb_if.sv
// ----------------------------------------------------------------------------
// pfnb_in_if / pfnb_out_if
// Valid/ready channels for input items and folded results.
// ----------------------------------------------------------------------------
interface pfnb_in_if import pfnb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic               reseed;
  logic [PHASE_W-1:0] start_phase;
  logic signed [PHASE_W-1:0] phase_step;
  logic signed [VAL_W-1:0]   sample_value;

  modport source(output valid, op, reseed, start_phase, phase_step, sample_value,
                 input ready);
  modport sink(input valid, op, reseed, start_phase, phase_step, sample_value,
               output ready);
endinterface

interface pfnb_out_if import pfnb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] folded_value;
  logic [OCH_W-1:0]        channel_index;
  logic [OBIN_W-1:0]       bin_index;
  logic                    was_filled;
  logic                    last;
  logic [STAT_W-1:0]       status;

  modport source(output valid, folded_value, channel_index, bin_index, was_filled,
                 last, status, input ready);
  modport sink(input valid, folded_value, channel_index, bin_index, was_filled,
               last, status, output ready);
endinterface

### design/phase_fold_nearest_bin_top.sv
// ----------------------------------------------------------------------------
// phase_fold_nearest_bin_top
// Folds channel samples into phase bins and reads back bin averages.
// ----------------------------------------------------------------------------
//  channel     dir  handshake     payload
//  sample_in   in   valid/ready   op, reseed, start_phase, phase_step, sample_value
//  result_out  out  valid/ready   folded_value, channel_index, bin_index,
//                                 was_filled, last, status
//  cfg         in   cfg_we        cfg_index, cfg_data
//
// A sample passes through bin select, sum/hit RAM read and write back.
// A read of an empty bin needs no divider; otherwise the serial divider
// forms sum/hits. Starting a readout and each new read channel runs the
// channel mean over the bins, bound by the divider.
// After reset and after the last read, a clearing pass sweeps the sum and
// hit RAMs, 2^(log2 MAX_CHANNELS + log2 MAX_BINS) sum addresses (16384
// by default). Input is taken only in the idle state while the result
// register is empty; output stalls hold it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module phase_fold_nearest_bin_top import pfnb_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_BINS     = DEF_MAX_BINS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  pfnb_in_if.sink              sample_in,
  pfnb_out_if.source           result_out
);

  localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int BW   = $clog2(MAX_BINS);
  localparam int AW   = CW + BW;
  localparam int MAXW = (CW > BW) ? CW : BW;
  localparam int CMPW = ((MAXW > 9) ? MAXW : 9) + 2;
  localparam int SUM_DEPTH = 1 << AW;
  localparam int HIT_DEPTH = 1 << BW;

  state_t state, state_next;

  logic [6:0]        cfg_channels;
  logic [8:0]        cfg_bins;
  logic [SCNT_W-1:0] cfg_samples;
  logic [CMPW-1:0]   nc_eff, nb_eff;
  logic [SCNT_W-1:0] ns_eff;

  logic [PHASE_W-1:0] phase_accum, step_reg, phase_sel;
  logic [BW-1:0]      current_bin, read_bin;
  logic [CW-1:0]      channel_count, read_channel;
  logic [SCNT_W-1:0]  sample_count;
  logic               readout_pending;
  logic [VAL_W-1:0]   channel_mean;
  logic [VAL_W-1:0]   sample_val;
  logic [AW-1:0]      clr_addr;
  logic [BW:0]        mbin, mcount;
  logic [SUM_W-1:0]   mtotal;

  logic [PHASE_W+CMPW-1:0] prod;
  logic [BW-1:0]           bin_calc;

  logic              acc;
  logic              sample_done, subint_done, bin_wrap, fin;
  logic              rd_emit, mean_begin, out_load;
  logic              div_start, div_busy, div_done;
  logic [SUM_W-1:0]  div_dividend, div_q;
  logic [HIT_W-1:0]  div_divisor;
  logic [VAL_W-1:0]  avg_sat;

  logic               sums_we, hits_we;
  logic [AW-1:0]      sums_waddr, sums_raddr;
  logic [BW-1:0]      hits_waddr, hits_raddr;
  logic [SUM_W-1:0]   sums_wdata, sums_rd;
  logic [HIT_W-1:0]   hits_wdata, hits_rd;

  logic               out_valid;
  logic [VAL_W-1:0]   out_value;
  logic [OCH_W-1:0]   out_channel;
  logic [OBIN_W-1:0]  out_bin;
  logic               out_filled, out_last;
  logic [STAT_W-1:0]  out_status;

  // Effective configuration.
  always_comb begin
    if (cfg_channels == '0) begin
      nc_eff = CMPW'(1);
    end else if (CMPW'(cfg_channels) > CMPW'(MAX_CHANNELS)) begin
      nc_eff = CMPW'(MAX_CHANNELS);
    end else begin
      nc_eff = CMPW'(cfg_channels);
    end
    if (CMPW'(cfg_bins) < CMPW'(2)) begin
      nb_eff = CMPW'(2);
    end else if (CMPW'(cfg_bins) > CMPW'(MAX_BINS)) begin
      nb_eff = CMPW'(MAX_BINS);
    end else begin
      nb_eff = CMPW'(cfg_bins);
    end
    ns_eff = (cfg_samples == '0) ? SCNT_W'(1) : cfg_samples;
  end

  assign sample_in.ready = (state == S_IDLE) && !out_valid;
  assign acc = sample_in.valid && sample_in.ready;

  assign phase_sel = (channel_count == '0 && sample_in.reseed) ? sample_in.start_phase
                                                                : phase_accum;
  assign prod     = (PHASE_W+CMPW)'(phase_sel) * (PHASE_W+CMPW)'(nb_eff);
  assign bin_calc = prod[PHASE_W +: BW];

  assign sample_done = (CMPW'(channel_count) + 1'b1) >= nc_eff;
  assign subint_done = sample_done && ((sample_count + 1'b1) >= ns_eff);
  assign bin_wrap    = (CMPW'(read_bin) + 1'b1) >= nb_eff;
  assign fin         = bin_wrap && ((CMPW'(read_channel) + 1'b1) >= nc_eff);

  assign avg_sat = sat32(div_q);

  // Next state and strobes.
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    rd_emit      = 1'b0;
    div_dividend = sums_rd;
    div_divisor  = hits_rd;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc && readout_pending && sample_in.op) begin
          state_next = S_RD;
        end else if (acc && !readout_pending && !sample_in.op) begin
          state_next = S_SREAD;
        end
      end
      S_SREAD: state_next = S_ACC;
      S_ACC: begin
        state_next = subint_done ? S_MADDR : S_IDLE;
      end
      S_RD: begin
        if (hits_rd == '0) begin
          rd_emit = 1'b1;
        end else begin
          div_start  = 1'b1;
          state_next = S_RDIV;
        end
      end
      S_RDIV: begin
        rd_emit = div_done;
      end
      S_MADDR: begin
        div_dividend = mtotal;
        div_divisor  = HIT_W'(mcount);
        if (CMPW'(mbin) >= nb_eff) begin
          if (mcount == '0) begin
            state_next = S_IDLE;
          end else begin
            div_start  = 1'b1;
            state_next = S_MFDIV;
          end
        end else begin
          state_next = S_MDATA;
        end
      end
      S_MDATA: begin
        if (hits_rd == '0) begin
          state_next = S_MADDR;
        end else begin
          div_start  = 1'b1;
          state_next = S_MDIV;
        end
      end
      S_MDIV: begin
        if (div_done) state_next = S_MADDR;
      end
      S_MFDIV: begin
        if (div_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (rd_emit) begin
      priority if (fin) begin
        state_next = S_CLEAR;
      end else if (bin_wrap) begin
        state_next = S_MADDR;
      end else begin
        state_next = S_IDLE;
      end
    end
  end

  assign mean_begin = (state == S_ACC && subint_done) || (rd_emit && !fin && bin_wrap);
  assign out_load   = rd_emit || (acc && (sample_in.op != readout_pending));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Memory ports.
  always_comb begin
    sums_we    = 1'b0;
    hits_we    = 1'b0;
    sums_waddr = {channel_count, current_bin};
    hits_waddr = current_bin;
    sums_wdata = sums_rd + {{(SUM_W-VAL_W){sample_val[VAL_W-1]}}, sample_val};
    hits_wdata = (hits_rd == '1) ? hits_rd : hits_rd + 1'b1;
    sums_raddr = {read_channel, read_bin};
    hits_raddr = read_bin;
    if (state == S_CLEAR) begin
      sums_we    = 1'b1;
      hits_we    = 1'b1;
      sums_waddr = clr_addr;
      hits_waddr = clr_addr[BW-1:0];
      sums_wdata = '0;
      hits_wdata = '0;
    end else if (state == S_ACC) begin
      sums_we = 1'b1;
      hits_we = (channel_count == '0);
    end
    if (state == S_SREAD) begin
      sums_raddr = {channel_count, current_bin};
      hits_raddr = current_bin;
    end else if (state == S_MADDR) begin
      sums_raddr = {read_channel, mbin[BW-1:0]};
      hits_raddr = mbin[BW-1:0];
    end
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_channels    <= 7'd1;
      cfg_bins        <= 9'd256;
      cfg_samples     <= SCNT_W'(1024);
      phase_accum     <= '0;
      step_reg        <= '0;
      current_bin     <= '0;
      channel_count   <= '0;
      sample_count    <= '0;
      readout_pending <= 1'b0;
      read_channel    <= '0;
      read_bin        <= '0;
      channel_mean    <= '0;
      clr_addr        <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_CHANNELS: cfg_channels <= cfg_data[6:0];
          CFG_NUM_BINS:     cfg_bins     <= cfg_data[8:0];
          CFG_SAMPLES:      cfg_samples  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && result_out.ready) out_valid <= 1'b0;

      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;

      if (acc) begin
        if (!sample_in.op && !readout_pending) begin
          sample_val <= sample_in.sample_value;
          if (channel_count == '0) begin
            if (sample_in.reseed) begin
              phase_accum <= sample_in.start_phase;
              step_reg    <= sample_in.phase_step;
            end
            current_bin <= bin_calc;
          end
        end
      end

      if (out_load) begin
        out_valid   <= 1'b1;
        out_value   <= '0;
        out_channel <= '0;
        out_bin     <= '0;
        out_filled  <= 1'b0;
        out_last    <= 1'b0;
        out_status  <= readout_pending ? STATUS_REJECT : STATUS_EMPTY;
        if (rd_emit) begin
          out_value   <= (state == S_RD) ? channel_mean : avg_sat;
          out_channel <= OCH_W'(read_channel);
          out_bin     <= OBIN_W'(read_bin);
          out_filled  <= (state == S_RD);
          out_last    <= fin;
          out_status  <= STATUS_VALUE;
        end
      end

      if (state == S_ACC) begin
        if (sample_done) begin
          channel_count <= '0;
          phase_accum   <= phase_accum + step_reg;
          sample_count  <= sample_count + 1'b1;
          if (subint_done) begin
            readout_pending <= 1'b1;
            read_channel    <= '0;
            read_bin        <= '0;
          end
        end else begin
          channel_count <= channel_count + 1'b1;
        end
      end

      if (rd_emit) begin
        priority if (fin) begin
          sample_count    <= '0;
          channel_count   <= '0;
          readout_pending <= 1'b0;
          read_channel    <= '0;
          read_bin        <= '0;
          channel_mean    <= '0;
          clr_addr        <= '0;
        end else if (bin_wrap) begin
          read_bin     <= '0;
          read_channel <= read_channel + 1'b1;
        end else begin
          read_bin <= read_bin + 1'b1;
        end
      end

      if (mean_begin) begin
        mbin   <= '0;
        mcount <= '0;
        mtotal <= '0;
      end

      if (state == S_MADDR && CMPW'(mbin) >= nb_eff && mcount == '0) begin
        channel_mean <= '0;
      end
      if (state == S_MDATA && hits_rd == '0) mbin <= mbin + 1'b1;
      if (state == S_MDIV && div_done) begin
        mtotal <= mtotal + {{(SUM_W-VAL_W){avg_sat[VAL_W-1]}}, avg_sat};
        mcount <= mcount + 1'b1;
        mbin   <= mbin + 1'b1;
      end
      if (state == S_MFDIV && div_done) channel_mean <= div_q[VAL_W-1:0];
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.folded_value  = out_value;
  assign result_out.channel_index = out_channel;
  assign result_out.bin_index     = out_bin;
  assign result_out.was_filled    = out_filled;
  assign result_out.last          = out_last;
  assign result_out.status        = out_status;

  pfnb_ram #(.WIDTH(SUM_W), .DEPTH(SUM_DEPTH)) u_sums (
    .clk   (clk),
    .we    (sums_we),
    .waddr (sums_waddr),
    .wdata (sums_wdata),
    .raddr (sums_raddr),
    .rdata (sums_rd)
  );

  pfnb_ram #(.WIDTH(HIT_W), .DEPTH(HIT_DEPTH)) u_hits (
    .clk   (clk),
    .we    (hits_we),
    .waddr (hits_waddr),
    .wdata (hits_wdata),
    .raddr (hits_raddr),
    .rdata (hits_rd)
  );

  pfnb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  `PFNB_ASSERT_IMP(a_div_free, clk, rst, div_start, !div_busy, "divider restarted while busy")
  `PFNB_ASSERT_IMP(a_out_free, clk, rst, out_load, !out_valid, "result register overwritten")
  `PFNB_ASSERT_IMP(a_acc_open, clk, rst, state == S_ACC, !readout_pending, "fold during readout")
  `PFNB_ASSERT_IMP(a_fin_clear, clk, rst, $fell(readout_pending), state == S_CLEAR,
                   "readout ended without clearing pass")

endmodule

### design/pfnb_ram.sv
// ----------------------------------------------------------------------------
// pfnb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfnb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pfnb_div.sv
// ----------------------------------------------------------------------------
// pfnb_div
// Restoring divider, one quotient bit per cycle: signed 56-bit dividend by
// a nonzero unsigned 24-bit divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pfnb_div import pfnb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [HIT_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W);

  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [HIT_W-1:0] dsr;
  logic [HIT_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic [HIT_W:0]   rem_sh;
  logic [HIT_W:0]   rem_diff;
  logic             ge;

  assign rem_sh   = {rem, quo[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[SUM_W-1];
        quo  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= ge ? rem_diff[HIT_W-1:0] : rem_sh[HIT_W-1:0];
        quo <= {quo[SUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
